>>> hw/rtl/lrx_pkg.sv
// shared types, constants and fixed-point helpers for the crossover
`timescale 1ns / 1ps
`default_nettype none

package lrx_pkg;

    // default values for the top-level parameters
    localparam int SECTIONS_DEF    = 2;
    localparam int SAMPLE_BITS_DEF = 24;

    // coefficient fraction bits
    localparam int GAIN_FRAC = 28;
    localparam int DAMP_FRAC = 30;
    localparam int NORM_FRAC = 30;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int NORM_W     = 31;

    localparam logic [31:0]       GAIN_RST = 32'd17594060;
    localparam logic [31:0]       DAMP_RST = 32'd1518500250;
    localparam logic [NORM_W-1:0] NORM_RST = 31'd978810000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN = 2'd0,
        CFG_DAMP = 2'd1,
        CFG_NORM = 2'd2
    } t_cfg_idx;

    // working width for sums ahead of saturation
    localparam int WIDE = 40;
    localparam logic signed [WIDE-1:0] SAT_HI = 40'sh00_7FFF_FFFF;
    localparam logic signed [WIDE-1:0] SAT_LO = 40'shFF_8000_0000;

    typedef struct packed {
        logic signed [31:0] s1;
        logic signed [31:0] s2;
    } t_sec_state;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_NORM,
        ST_V1,
        ST_V2,
        ST_HP,
        ST_DONE
    } t_state;

    function automatic logic signed [WIDE-1:0] ext32(input logic signed [31:0] v);
        return WIDE'(v);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [WIDE-1:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_LO) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // add half an lsb, then floor shift
    function automatic logic signed [WIDE-1:0] rnd_shift(input logic signed [64:0] p,
                                                         input int unsigned n);
        logic signed [65:0] q;
        q = 66'(p) + (66'sd1 <<< (n - 1));
        return WIDE'(q >>> n);
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lrx_ifs.sv
// valid/ready channel interfaces for sample, band and configuration transactions
`timescale 1ns / 1ps
`default_nettype none

interface lrx_sample_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface lrx_band_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] low_band;
    logic signed [SAMPLE_BITS-1:0] high_band;

    modport source (output valid, output low_band, output high_band, input ready);
    modport sink   (input valid, input low_band, input high_band, output ready);
endinterface

interface lrx_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/linkwitz_riley_iir_crossover.sv
// two-band linkwitz-riley crossover on one shared multiplier under a sequencer
`timescale 1ns / 1ps
`default_nettype none

// usage
// - i_sample: one signed sample per transaction, taken only while the sequencer is idle
// - o_band: low and high band sample per transaction, from an output register
// - i_cfg: register writes (0 cutoff gain, 1 damping, 2 normalizer), always ready;
//   write only while no sample is in flight; unknown indexes are dropped
// timing
// - each biquad runs on one 33x32 multiplier with a product register: a lowpass
//   section steps DIFF, NORM, V1, V2; a highpass section adds HP (extra damping product)
// - o_band.valid rises once ST_DONE loads the result into the output register;
//   a new sample is taken only once the sequencer is back in idle, not while one is in flight
// - the sequencer handing its result over sets the rate; one result can wait in
//   the output register while the next sample is being worked on
// reset
// - synchronous, active low: integrators cleared, coefficients to defaults,
//   output register emptied
// stall
// - if the result register is still full when the next result is done, the
//   sequencer holds in its done step and takes no new sample until o_band drains
module linkwitz_riley_iir_crossover
    import lrx_pkg::*;
#(
    parameter int SECTIONS    = SECTIONS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    lrx_sample_if.sink  i_sample,
    lrx_band_if.source  o_band,
    lrx_cfg_if.sink     i_cfg
);

    localparam int NST   = 2 * SECTIONS;
    localparam int IDX_W = $clog2(NST);
    localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

    // output saturation limits, held as 32-bit signed
    localparam logic [31:0] SMAX_U = 32'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [31:0] SMAX = $signed(SMAX_U);
    localparam logic signed [31:0] SMIN = ~SMAX;

    // coefficient registers
    logic [31:0]       r_gain;
    logic [31:0]       r_damp;
    logic [NORM_W-1:0] r_norm;

    // integrator bank: low chain sections first, then high chain
    t_sec_state r_st [NST];

    // sequencer
    t_state           r_state, n_state;
    logic             r_chain, n_chain;       // 0 low chain, 1 high chain
    logic [SEC_W-1:0] r_sec, n_sec;

    // datapath registers
    logic signed [31:0] r_x, n_x;             // input sample, sign extended
    logic signed [31:0] r_v, n_v;             // signal entering the current section
    logic signed [31:0] r_v1, n_v1;
    logic signed [31:0] r_v2, n_v2;
    logic signed [31:0] r_lo, n_lo;
    logic signed [31:0] r_hi, n_hi;
    logic signed [64:0] r_prod;

    // output register
    logic                          r_out_valid, n_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_lo, n_out_lo;
    logic signed [SAMPLE_BITS-1:0] r_out_hi, n_out_hi;

    // shared multiplier operands
    logic signed [31:0] w_mul_a;
    logic [31:0]        w_mul_c;
    logic signed [64:0] w_mul;

    logic [IDX_W-1:0] w_idx;
    t_sec_state       w_cur;
    logic             w_st_we;
    t_sec_state       w_st_new;
    logic             w_last_sec;
    logic             w_in_take;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [31:0] v);
        logic signed [31:0] r;
        if (v > SMAX) begin
            r = SMAX;
        end else if (v < SMIN) begin
            r = SMIN;
        end else begin
            r = v;
        end
        return r[SAMPLE_BITS-1:0];
    endfunction

    assign w_idx      = IDX_W'(r_chain ? SECTIONS : 0) + IDX_W'(r_sec);
    assign w_cur      = r_st[w_idx];
    assign w_last_sec = (r_sec == SEC_W'(SECTIONS - 1));
    assign w_in_take  = i_sample.valid && i_sample.ready;

    assign i_sample.ready   = (r_state == ST_IDLE);
    assign o_band.valid     = r_out_valid;
    assign o_band.low_band  = r_out_lo;
    assign o_band.high_band = r_out_hi;
    assign i_cfg.ready      = 1'b1;

    // the one multiplier: signed signal times unsigned coefficient
    assign w_mul = 65'(w_mul_a) * 65'($signed({1'b0, w_mul_c}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        logic signed [31:0] diff;
        logic signed [31:0] t;
        logic signed [31:0] t2;
        logic signed [31:0] v1;
        logic signed [31:0] v2;
        logic signed [31:0] hp;
        n_state     = r_state;
        n_chain     = r_chain;
        n_sec       = r_sec;
        n_x         = r_x;
        n_v         = r_v;
        n_v1        = r_v1;
        n_v2        = r_v2;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_out_valid = r_out_valid && !o_band.ready;
        n_out_lo    = r_out_lo;
        n_out_hi    = r_out_hi;
        w_mul_a     = r_v1;
        w_mul_c     = r_damp;
        w_st_we     = 1'b0;
        w_st_new    = w_cur;
        diff        = sat32(ext32(r_v) - ext32(w_cur.s2));
        t           = sat32(rnd_shift(r_prod, GAIN_FRAC));
        t2          = sat32(ext32(w_cur.s1) + ext32(t));
        v1          = sat32(rnd_shift(r_prod, NORM_FRAC));
        v2          = sat32(ext32(w_cur.s2) + rnd_shift(r_prod, GAIN_FRAC));
        hp          = sat32(ext32(r_v) - rnd_shift(r_prod, DAMP_FRAC) - ext32(r_v2));
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_take) begin
                    n_x     = 32'(i_sample.sample_in);
                    n_v     = 32'(i_sample.sample_in);
                    n_chain = 1'b0;
                    n_sec   = '0;
                    n_state = ST_DIFF;
                end
            end
            ST_DIFF: begin
                // g * (v0 - s2)
                w_mul_a = diff;
                w_mul_c = r_gain;
                n_state = ST_NORM;
            end
            ST_NORM: begin
                // normalizer * (s1 + g-term)
                w_mul_a = t2;
                w_mul_c = 32'(r_norm);
                n_state = ST_V1;
            end
            ST_V1: begin
                n_v1    = v1;
                w_mul_a = v1;
                w_mul_c = r_gain;
                n_state = ST_V2;
            end
            ST_V2: begin
                // integrator update, then either pass v2 on or form the highpass
                n_v2        = v2;
                w_st_we     = 1'b1;
                w_st_new.s1 = sat32((ext32(r_v1) <<< 1) - ext32(w_cur.s1));
                w_st_new.s2 = sat32((ext32(v2) <<< 1) - ext32(w_cur.s2));
                w_mul_a     = r_v1;
                w_mul_c     = r_damp;
                if (r_chain) begin
                    n_state = ST_HP;
                end else if (w_last_sec) begin
                    n_lo    = v2;
                    n_v     = r_x;
                    n_chain = 1'b1;
                    n_sec   = '0;
                    n_state = ST_DIFF;
                end else begin
                    n_v     = v2;
                    n_sec   = r_sec + SEC_W'(1);
                    n_state = ST_DIFF;
                end
            end
            ST_HP: begin
                if (w_last_sec) begin
                    n_hi    = hp;
                    n_state = ST_DONE;
                end else begin
                    n_v     = hp;
                    n_sec   = r_sec + SEC_W'(1);
                    n_state = ST_DIFF;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_band.ready) begin
                    n_out_valid = 1'b1;
                    n_out_lo    = sat_sample(r_lo);
                    n_out_hi    = sat_sample(r_hi);
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer position, datapath and output registers
    always_ff @(posedge i_clk) begin
        r_x         <= n_x;
        r_v         <= n_v;
        r_v1        <= n_v1;
        r_v2        <= n_v2;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_prod      <= w_mul;
        r_out_lo    <= n_out_lo;
        r_out_hi    <= n_out_hi;
        if (!i_rst_n) begin
            r_chain     <= 1'b0;
            r_sec       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_chain     <= n_chain;
            r_sec       <= n_sec;
            r_out_valid <= n_out_valid;
        end
    end

    // integrator bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NST; i++) begin
                r_st[i] <= '0;
            end
        end else if (w_st_we) begin
            r_st[w_idx] <= w_st_new;
        end
    end

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RST;
            r_damp <= DAMP_RST;
            r_norm <= NORM_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_GAIN: r_gain <= i_cfg.data;
                CFG_DAMP: r_damp <= i_cfg.data;
                CFG_NORM: r_norm <= i_cfg.data[NORM_W-1:0];
                default:  ;
            endcase
        end
    end

    // a taken sample always starts at the first low section
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> (r_state == ST_DIFF && !r_chain && r_sec == '0))
        else $error("sequencer did not start at first low section");

    // finishing a sample fills the output register
    a_done_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && n_state == ST_IDLE) |=> r_out_valid)
        else $error("result not loaded into output register");

    // section counter stays within the chain
    a_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sec <= SEC_W'(SECTIONS - 1))
        else $error("section counter out of range");

    // highpass combine only happens on the high chain
    a_hp_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HP) |-> r_chain)
        else $error("highpass step on low chain");

endmodule

`default_nettype wire
